// ===== rtl/vms_pkg.sv =====
`timescale 1ns / 1ps
package vms_pkg;

	localparam int GRID_SIZE = 32;
	localparam int CW        = $clog2(GRID_SIZE);
	localparam int AW        = 3 * CW;
	localparam int DEPTH     = 1 << AW;
	// Wide enough for (c +/- h) * GRID_SIZE + 65535 at GRID_SIZE up to 128
	localparam int PW        = 28;
	localparam int FRAC_BITS = 16;

	localparam logic [1:0] KIND_SPLAT = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic load;
		logic corner;
		logic walk_init;
		logic walk_step;
		logic clr_init;
		logic clr_step;
		logic rd_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic clr_last;
	} sts_t;

	function automatic logic [CW-1:0] clamp_grid(input logic signed [PW-1:0] v);
		logic [CW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > PW'(GRID_SIZE - 1)) begin
			r = CW'(GRID_SIZE - 1);
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	// floor((c - h) * GRID_SIZE / 65536), clamped
	function automatic logic [CW-1:0] lo_corner(input logic signed [17:0] c,
		input logic [15:0] h);
		logic signed [PW-1:0] s;
		s = PW'(c) - PW'($signed({1'b0, h}));
		s = s * PW'(GRID_SIZE);
		return clamp_grid(s >>> FRAC_BITS);
	endfunction

	// ceil((c + h) * GRID_SIZE / 65536), clamped
	function automatic logic [CW-1:0] hi_corner(input logic signed [17:0] c,
		input logic [15:0] h);
		logic signed [PW-1:0] s;
		s = PW'(c) + PW'($signed({1'b0, h}));
		s = s * PW'(GRID_SIZE);
		s = s + PW'((1 << FRAC_BITS) - 1);
		return clamp_grid(s >>> FRAC_BITS);
	endfunction

	// A fresh value with the sign bit set never wins
	function automatic logic [31:0] max_bits(input logic [31:0] stored,
		input logic [31:0] fresh);
		logic [31:0] r;
		if (fresh[31]) begin
			r = stored;
		end else if (fresh > stored) begin
			r = fresh;
		end else begin
			r = stored;
		end
		return r;
	endfunction

endpackage

// ===== rtl/voxel_max_splatter.sv =====
`timescale 1ns / 1ps
// Splat: one read-modify-write per voxel in the clamped box on the grid memory port.
// One item at a time, not taken before the last is done; the next item is taken while a
// finished result waits for out_ready.
// Reset: asynchronous, clears control; then a pass over every address zeroes both grids
// before the first item is accepted.
module voxel_max_splatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [17:0] center_x,
	input  logic signed [17:0] center_y,
	input  logic signed [17:0] center_z,
	input  logic [15:0]        half_size,
	input  logic [31:0]        density_bits,
	input  logic [31:0]        temperature_bits,
	input  logic [4:0]         voxel_x,
	input  logic [4:0]         voxel_y,
	input  logic [4:0]         voxel_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        voxel_density,
	output logic [31:0]        voxel_temperature
);
	import vms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	vms_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.center_x          (center_x),
		.center_y          (center_y),
		.center_z          (center_z),
		.half_size         (half_size),
		.kind              (kind),
		.density_bits      (density_bits),
		.temperature_bits  (temperature_bits),
		.voxel_x           (voxel_x),
		.voxel_y           (voxel_y),
		.voxel_z           (voxel_z),
		.voxel_density     (voxel_density),
		.voxel_temperature (voxel_temperature)
	);

endmodule

// ===== rtl/vms_dp.sv =====
`timescale 1ns / 1ps
module vms_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  vms_pkg::cmd_t       cmd,
	output vms_pkg::sts_t       sts,
	input  logic signed [17:0]  center_x,
	input  logic signed [17:0]  center_y,
	input  logic signed [17:0]  center_z,
	input  logic [15:0]         half_size,
	input  logic [1:0]          kind,
	input  logic [31:0]         density_bits,
	input  logic [31:0]         temperature_bits,
	input  logic [4:0]          voxel_x,
	input  logic [4:0]          voxel_y,
	input  logic [4:0]          voxel_z,
	output logic [31:0]         voxel_density,
	output logic [31:0]         voxel_temperature
);
	import vms_pkg::*;

	logic [1:0]         kind_q;
	logic signed [17:0] cx_q, cy_q, cz_q;
	logic [15:0]        h_q;
	logic [31:0]        dens_q, temp_q;
	logic [4:0]         vx_q, vy_q, vz_q;

	logic [CW-1:0] xlo_q, xhi_q, ylo_q, yhi_q, zlo_q, zhi_q;
	logic [CW-1:0] x_q, y_q, z_q;
	logic [AW-1:0] clr_q;

	logic [31:0] dens_mem [DEPTH];
	logic [31:0] temp_mem [DEPTH];
	logic [31:0] dens_rd_q, temp_rd_q;

	logic          rmw_s1;
	logic [AW-1:0] addr_s1;

	logic          re, we;
	logic [AW-1:0] raddr, waddr;
	logic [31:0]   dens_wd, temp_wd;
	logic          in_grid;
	logic          x_end, y_end, z_end;

	logic [31:0] dens_out_q, temp_out_q;

	assign x_end = (x_q == xhi_q);
	assign y_end = (y_q == yhi_q);
	assign z_end = (z_q == zhi_q);
	assign sts.walk_last = x_end && y_end && z_end;
	assign sts.clr_last  = &clr_q;

	assign in_grid = ({3'b000, vx_q} < 8'(GRID_SIZE)) && ({3'b000, vy_q} < 8'(GRID_SIZE))
		&& ({3'b000, vz_q} < 8'(GRID_SIZE));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			cx_q   <= center_x;
			cy_q   <= center_y;
			cz_q   <= center_z;
			h_q    <= half_size;
			dens_q <= density_bits;
			temp_q <= temperature_bits;
			vx_q   <= voxel_x;
			vy_q   <= voxel_y;
			vz_q   <= voxel_z;
		end
		if (cmd.corner) begin
			xlo_q <= lo_corner(cx_q, h_q);
			xhi_q <= hi_corner(cx_q, h_q);
			ylo_q <= lo_corner(cy_q, h_q);
			yhi_q <= hi_corner(cy_q, h_q);
			zlo_q <= lo_corner(cz_q, h_q);
			zhi_q <= hi_corner(cz_q, h_q);
		end
		// Walk x fastest, then y, then z
		if (cmd.walk_init) begin
			x_q <= xlo_q;
			y_q <= ylo_q;
			z_q <= zlo_q;
		end else if (cmd.walk_step) begin
			if (x_end) begin
				x_q <= xlo_q;
				if (y_end) begin
					y_q <= ylo_q;
					z_q <= z_q + 1'b1;
				end else begin
					y_q <= y_q + 1'b1;
				end
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (cmd.walk_step) begin
			addr_s1 <= {z_q, y_q, x_q};
		end
		if (cmd.out_load) begin
			dens_out_q <= (kind_q == KIND_READ && in_grid) ? dens_rd_q : '0;
			temp_out_q <= (kind_q == KIND_READ && in_grid) ? temp_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_s1 <= 1'b0;
			clr_q  <= '0;
		end else begin
			rmw_s1 <= cmd.walk_step;
			if (cmd.clr_init) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign re    = cmd.walk_step || cmd.rd_issue;
	assign raddr = cmd.walk_step ? {z_q, y_q, x_q}
		: {CW'(vz_q), CW'(vy_q), CW'(vx_q)};

	// Write back in the cycle after the read; addresses within a splat never repeat
	assign we      = rmw_s1 || cmd.clr_step;
	assign waddr   = cmd.clr_step ? clr_q : addr_s1;
	assign dens_wd = cmd.clr_step ? '0 : max_bits(dens_rd_q, dens_q);
	assign temp_wd = cmd.clr_step ? '0 : max_bits(temp_rd_q, temp_q);

	always_ff @(posedge clk) begin
		if (we) begin
			dens_mem[waddr] <= dens_wd;
			temp_mem[waddr] <= temp_wd;
		end
		if (re) begin
			dens_rd_q <= dens_mem[raddr];
			temp_rd_q <= temp_mem[raddr];
		end
	end

	assign voxel_density     = dens_out_q;
	assign voxel_temperature = temp_out_q;

endmodule

// ===== rtl/vms_ctrl.sv =====
`timescale 1ns / 1ps
module vms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	output logic          out_valid,
	input  logic          out_ready,
	output vms_pkg::cmd_t cmd,
	input  vms_pkg::sts_t sts
);
	import vms_pkg::*;

	localparam logic [2:0] ST_CLRI   = 3'd0;
	localparam logic [2:0] ST_CLR    = 3'd1;
	localparam logic [2:0] ST_IDLE   = 3'd2;
	localparam logic [2:0] ST_CORNER = 3'd3;
	localparam logic [2:0] ST_INIT   = 3'd4;
	localparam logic [2:0] ST_WALK   = 3'd5;
	localparam logic [2:0] ST_RD     = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       owe_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLRI: begin
				cmd.clr_init = 1'b1;
				state_d      = ST_CLR;
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = owe_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (kind)
						KIND_SPLAT: state_d = ST_CORNER;
						KIND_READ:  state_d = ST_RD;
						KIND_CLEAR: state_d = ST_CLRI;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_CORNER: begin
				cmd.corner = 1'b1;
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// Hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLRI;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLRI;
			owe_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				owe_q <= 1'b1;
			end else if (cmd.out_load) begin
				owe_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
